/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the framed byte queue.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define FBQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: lbl");
// Check that a condition never holds outside reset.
`define FBQ_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen: lbl");
`else
`define FBQ_ASSERT(lbl, clk, rst, prop)
`define FBQ_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* hw/rtl/fbq_pkg.sv */
// Package of the framed byte queue: operation codes, result status codes
// and frame marker bytes. No dependencies.
package fbq_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    STATUS_STORED  = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_FRAME   = 2'd2
  } status_t;

  localparam logic [7:0] HEAD_BYTE0  = 8'hBE;
  localparam logic [7:0] HEAD_BYTE1  = 8'hEF;
  localparam logic [7:0] TRAIL_BYTE0 = 8'hDE;
  localparam logic [7:0] TRAIL_BYTE1 = 8'hAD;

endpackage

/* hw/rtl/fbq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/fbq_step.sv */
// Shared pointer/count step unit of the framed byte queue: wrap-around
// pointer increment and fill count adjust. No dependencies.
module fbq_step #(
  parameter int DEPTH = 32
) (
  input  logic [$clog2(DEPTH)-1:0]   ptr,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  logic                       down,
  output logic [$clog2(DEPTH)-1:0]   ptr_inc,
  output logic [$clog2(DEPTH+1)-1:0] count_adj
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  // Wrap at DEPTH, which need not be a power of two.
  assign ptr_inc   = (ptr == PTR_LAST) ? '0 : ptr + PW'(1);
  assign count_adj = down ? count - CW'(1) : count + CW'(1);

endmodule

/* hw/rtl/fbq_ctrl.sv */
// Sequencer of the framed byte queue: pointers, fill count, flush framing
// and the result register. Uses fbq_pkg, fbq_step and assert_macros.svh.
`include "assert_macros.svh"
module fbq_ctrl #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       operation,
  input  logic [7:0]                 data_byte,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [7:0]                 out_byte,
  output logic [1:0]                 status,
  output logic                       last,
  output logic                       wr_en,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic [7:0]                 wr_data,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic [7:0]                 rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_HEAD0  = 6'b000010,
    S_HEAD1  = 6'b000100,
    S_DATA   = 6'b001000,
    S_TRAIL0 = 6'b010000,
    S_TRAIL1 = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [PW-1:0]       rptr, rptr_next;
  logic [PW-1:0]       wptr, wptr_next;
  logic [CW-1:0]       count, count_next;
  logic                out_free;
  logic                load;
  logic [7:0]          ld_byte;
  fbq_pkg::status_t    ld_status;
  logic                ld_last;
  logic [PW-1:0]       step_ptr;
  logic [PW-1:0]       ptr_inc;
  logic [CW-1:0]       count_adj;
  logic                step_down;

  assign out_free  = !res_valid || !res_stall;
  assign req_stall = !((state == S_IDLE) && out_free);

  // One step unit serves the write pointer on writes, the read pointer while draining.
  assign step_down = (state == S_DATA);
  assign step_ptr  = step_down ? rptr : wptr;

  fbq_step #(.DEPTH(DEPTH)) u_step (
    .ptr       (step_ptr),
    .count     (count),
    .down      (step_down),
    .ptr_inc   (ptr_inc),
    .count_adj (count_adj)
  );

  always_comb begin
    state_next = state;
    rptr_next  = rptr;
    wptr_next  = wptr;
    count_next = count;
    load       = 1'b0;
    ld_byte    = '0;
    ld_status  = fbq_pkg::STATUS_FRAME;
    ld_last    = 1'b0;
    wr_en      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid && out_free) begin
          if (operation == fbq_pkg::OP_WRITE) begin
            load    = 1'b1;
            ld_last = 1'b1;
            if (count == COUNT_FULL) begin
              ld_status = fbq_pkg::STATUS_DROPPED;
            end else begin
              ld_status  = fbq_pkg::STATUS_STORED;
              wr_en      = 1'b1;
              wptr_next  = ptr_inc;
              count_next = count_adj;
            end
          end else begin
            state_next = S_HEAD0;
          end
        end
      end
      S_HEAD0: begin
        if (out_free) begin
          load       = 1'b1;
          ld_byte    = fbq_pkg::HEAD_BYTE0;
          state_next = S_HEAD1;
        end
      end
      S_HEAD1: begin
        if (out_free) begin
          load       = 1'b1;
          ld_byte    = fbq_pkg::HEAD_BYTE1;
          state_next = (count == '0) ? S_TRAIL0 : S_DATA;
        end
      end
      S_DATA: begin
        if (out_free) begin
          load       = 1'b1;
          ld_byte    = rd_data;
          rptr_next  = ptr_inc;
          count_next = count_adj;
          if (count == COUNT_ONE) begin
            state_next = S_TRAIL0;
          end
        end
      end
      S_TRAIL0: begin
        if (out_free) begin
          load       = 1'b1;
          ld_byte    = fbq_pkg::TRAIL_BYTE0;
          state_next = S_TRAIL1;
        end
      end
      S_TRAIL1: begin
        if (out_free) begin
          load       = 1'b1;
          ld_byte    = fbq_pkg::TRAIL_BYTE1;
          ld_last    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Read ahead: address the RAM with the pointer the next cycle will hold.
  assign rd_addr = rptr_next;
  assign wr_addr = wptr;
  assign wr_data = data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rptr      <= '0;
      wptr      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      rptr  <= rptr_next;
      wptr  <= wptr_next;
      count <= count_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= ld_byte;
      status   <= ld_status;
      last     <= ld_last;
    end
  end

  `FBQ_ASSERT_NEVER(a_count_bound, clk, rst, count > COUNT_FULL)
  `FBQ_ASSERT(a_empty_ptrs, clk, rst, (count == '0) |-> (rptr == wptr))
  `FBQ_ASSERT(a_drained, clk, rst, (state == S_TRAIL0) |-> (count == '0))
  `FBQ_ASSERT(a_write_room, clk, rst, wr_en |-> (count < COUNT_FULL))
  `FBQ_ASSERT(a_take_idle, clk, rst, (!req_stall) |-> (state == S_IDLE))

endmodule

/* hw/rtl/framed_byte_queue.sv */
// Top level of the framed byte queue: byte store RAM plus sequencer.
// Uses fbq_pkg, fbq_ram, fbq_step and fbq_ctrl.
//
// Usage:
//   Request channel (req_valid / req_stall): operation selects a write of
//   data_byte or a flush. A write stores the byte at the tail of a circular
//   queue of DEPTH bytes; with the queue full the byte is dropped instead.
//   Result channel (res_valid / res_stall): a write returns one result,
//   status stored or dropped, out_byte zero, last set. A flush returns the
//   frame BE EF, every stored byte oldest first, then DE AD, all with
//   status frame and last set only on AD; the queue is empty afterwards.
// Timing:
//   A write's result is valid the cycle after the request; back-to-back
//   writes run at one per cycle while results are taken. A flush holds
//   req_stall while the sequencer loads BE in HEAD0, EF in HEAD1, each
//   stored byte in DATA, then DE in TRAIL0 and AD in TRAIL1.
// Reset clears pointers, fill count and the result valid flag; the byte
// store is not cleared, since only written entries are ever read.
// A stalled result holds in the output register; the sequencer waits and
// no request is taken until it drains.
module framed_byte_queue #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       operation,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       last
);

  localparam int PW = $clog2(DEPTH);

  // Byte store port signals between sequencer and RAM.
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;

  fbq_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fbq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench of framed_byte_queue: directed and random write/flush requests,
// every result checked against a scoreboard that mirrors the queue.
// Depends on fbq_pkg and the framed_byte_queue RTL.

class frame_scoreboard #(int DEPTH = 32);
  typedef struct packed {
    logic [7:0]       value;
    fbq_pkg::status_t stat;
    logic             is_last;
  } frame_result_t;

  logic [7:0]    shadow_store [DEPTH];
  int            head_idx;
  int            tail_idx;
  int            held_count;
  frame_result_t pending_results [$];
  int            fail_count;
  int            n_stored;
  int            n_dropped;
  int            n_flushes;
  int            n_checked;

  function void push_result(logic [7:0] value, fbq_pkg::status_t stat, logic is_last);
    frame_result_t r;
    r.value   = value;
    r.stat    = stat;
    r.is_last = is_last;
    pending_results.push_back(r);
  endfunction

  // Mirror the queue for one accepted request and queue up its results.
  function void note_request(logic op, logic [7:0] data);
    if (op == fbq_pkg::OP_WRITE) begin
      if (held_count >= DEPTH) begin
        push_result(8'h00, fbq_pkg::STATUS_DROPPED, 1'b1);
        n_dropped++;
      end else begin
        shadow_store[tail_idx] = data;
        tail_idx = (tail_idx + 1) % DEPTH;
        held_count++;
        push_result(8'h00, fbq_pkg::STATUS_STORED, 1'b1);
        n_stored++;
      end
    end else begin
      push_result(fbq_pkg::HEAD_BYTE0, fbq_pkg::STATUS_FRAME, 1'b0);
      push_result(fbq_pkg::HEAD_BYTE1, fbq_pkg::STATUS_FRAME, 1'b0);
      while (held_count > 0) begin
        push_result(shadow_store[head_idx], fbq_pkg::STATUS_FRAME, 1'b0);
        head_idx = (head_idx + 1) % DEPTH;
        held_count--;
      end
      push_result(fbq_pkg::TRAIL_BYTE0, fbq_pkg::STATUS_FRAME, 1'b0);
      push_result(fbq_pkg::TRAIL_BYTE1, fbq_pkg::STATUS_FRAME, 1'b1);
      n_flushes++;
    end
  endfunction

  task report(string msg);
    fail_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task check_result(logic [7:0] value, logic [1:0] stat, logic is_last);
    frame_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result byte %02h stat %0d last %0b",
                       value, stat, is_last));
    end else begin
      want = pending_results.pop_front();
      n_checked++;
      if (value !== want.value)
        report($sformatf("result %0d: byte %02h, want %02h", n_checked, value, want.value));
      if (stat !== want.stat)
        report($sformatf("result %0d: stat %0d, want %0d", n_checked, stat, want.stat));
      if (is_last !== want.is_last)
        report($sformatf("result %0d: last %0b, want %0b", n_checked, is_last,
                         want.is_last));
    end
  endtask

  task close_out();
    if (pending_results.size() != 0)
      report($sformatf("%0d expected results never arrived", pending_results.size()));
  endtask
endclass

module tb;
  localparam int QUEUE_DEPTH  = 32;
  localparam int N_RANDOM     = 500;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 150;
  localparam int DRAIN_CYCLES = 40;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic       operation;
  logic [7:0] data_byte;
  logic       res_valid;
  logic       res_stall;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  // Result-side stall is the OR of the per-result idling and the long hold.
  logic rx_idle;
  logic hold_off;
  assign res_stall = rx_idle | hold_off;

  int cycles;
  int n_accepted;
  int tx_streak;
  int rx_streak;

  frame_scoreboard #(QUEUE_DEPTH) sb;

  framed_byte_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Draw the idle cycles before the next request or result. Now and then
  // start a streak of back-to-back traffic so full-rate phases get hit too.
  function automatic int draw_gap(inout int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      streak = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Offer one request: idle for the drawn gap, then hold the payload steady
  // until a rising edge sees valid high and stall low.
  task automatic send_request(input logic op, input logic [7:0] data);
    int gap;
    gap = draw_gap(tx_streak);
    @(negedge clk);
    if (gap != 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    data_byte = data;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(op, data);
    n_accepted++;
  endtask

  // Result sink: stall for the drawn gap, then take one result and check it.
  initial begin : result_sink
    int gap;
    rx_idle = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = draw_gap(rx_streak);
      @(negedge clk);
      if (gap != 0) begin
        rx_idle = 1'b1;
        repeat (gap) @(negedge clk);
      end
      rx_idle = 1'b0;
      do @(posedge clk); while (!(res_valid === 1'b1 && !res_stall));
      sb.check_result(out_byte, status, last);
    end
  end

  // Long hold on the result side while the sender keeps offering requests:
  // the output register fills, so the block must stall its request side.
  initial begin : long_hold
    hold_off = 1'b0;
    wait (n_accepted >= HOLD_AT);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests accepted", cycles, n_accepted);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] corner_bytes [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA,
                                     8'h01, 8'h80, 8'h7F, 8'hFE};
    int sent;
    int kind;
    int run_len;

    rst       = 1'b1;
    req_valid = 1'b0;
    operation = fbq_pkg::OP_WRITE;
    data_byte = 8'h00;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Flush an empty queue: header and trailer only, last on the final byte.
    send_request(fbq_pkg::OP_FLUSH, 8'h00);
    // Flush again with a busy data field, which must be ignored.
    send_request(fbq_pkg::OP_FLUSH, 8'hFF);
    // Store the corner byte values, then drain them in one frame.
    foreach (corner_bytes[i]) send_request(fbq_pkg::OP_WRITE, corner_bytes[i]);
    send_request(fbq_pkg::OP_FLUSH, 8'h5A);
    // Single byte frame, then a flush right after the queue went empty.
    send_request(fbq_pkg::OP_WRITE, 8'hC3);
    send_request(fbq_pkg::OP_FLUSH, 8'h00);
    send_request(fbq_pkg::OP_FLUSH, 8'h3C);

    // Random part: mostly write runs closed by a flush. Short runs keep
    // the frames quick; runs around the depth fill the queue and force
    // drops. A few bursts of random requests break the pattern and leave
    // partial runs behind for the next frame.
    sent = 0;
    while (sent < N_RANDOM) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        run_len = $urandom_range(0, 12);
      end else if (kind < 9) begin
        run_len = $urandom_range(QUEUE_DEPTH - 4, QUEUE_DEPTH + 8);
      end else begin
        run_len = -1;
      end
      if (run_len < 0) begin
        repeat (8) begin
          send_request(1'($urandom_range(0, 1)), 8'($urandom));
          sent++;
        end
      end else begin
        repeat (run_len) begin
          send_request(fbq_pkg::OP_WRITE, 8'($urandom));
          sent++;
        end
        send_request(fbq_pkg::OP_FLUSH, 8'($urandom));
        sent++;
      end
    end

    @(negedge clk);
    req_valid = 1'b0;

    // Drain: wait for every queued result, then give stray results a chance.
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();

    $display("ran %0d requests: %0d bytes stored, %0d dropped on a full queue, %0d frames",
             n_accepted, sb.n_stored, sb.n_dropped, sb.n_flushes);
    $display("checked %0d results in %0d cycles, %0d mismatches",
             sb.n_checked, cycles, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/fbq_pkg.sv
hw/rtl/fbq_ram.sv
hw/rtl/fbq_step.sv
hw/rtl/fbq_ctrl.sv
hw/rtl/framed_byte_queue.sv
verif/tb.sv
